FILE: design/ufc_pkg.sv
// ----------------------------------------------------------------------------
// ufc_pkg
// Shared constants for the union-find component counter: field widths,
// default node count and operation codes.
// ----------------------------------------------------------------------------
package ufc_pkg;

	localparam int FIELD_W        = 10;
	localparam int COUNT_W        = 11;
	localparam int NODE_COUNT_DEF = 1024;
	localparam int COUNT_MAX      = (1 << COUNT_W) - 1;

	localparam logic MODE_ACTIVATE = 1'b0;
	localparam logic MODE_UNION    = 1'b1;

endpackage

FILE: design/union_find_component_counter.sv
// ----------------------------------------------------------------------------
// union_find_component_counter
// Activate item: the result is loaded once the output register is free.
// Union item: both fields are reduced modulo NODE_COUNT, then each find
// walks to its root and compresses the walked path; a link follows when
// the roots differ. The walk is set by one parent table read per step.
// Items are taken only in idle. Reset: a clearing pass writes every parent
// entry with its own index, one entry per cycle; no item is accepted meanwhile.
// ----------------------------------------------------------------------------
module union_find_component_counter #(
	parameter int NODE_COUNT = ufc_pkg::NODE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [ufc_pkg::FIELD_W-1:0] node_a,
	input  logic [ufc_pkg::FIELD_W-1:0] node_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ufc_pkg::COUNT_W-1:0] component_count,
	output logic                        merged
);
	import ufc_pkg::*;

	localparam int NW    = $clog2(NODE_COUNT);
	localparam int LIMIT = (NODE_COUNT > COUNT_MAX) ? COUNT_MAX : NODE_COUNT;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MOD    = 3'd2;
	localparam logic [2:0] ST_FSTART = 3'd3;
	localparam logic [2:0] ST_WALK   = 3'd4;
	localparam logic [2:0] ST_COMP   = 3'd5;
	localparam logic [2:0] ST_LINK   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]         state_q;
	logic [NW-1:0]      clr_q;
	logic               mode_q;
	logic [NW-1:0]      cur_q, start_q, n_q, root_q, ra_q, b_q;
	logic               phase_q;
	logic               merged_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_merged_q;

	logic               red_start, red_done;
	logic [NW-1:0]      red_a, red_b;

	logic               we;
	logic [NW-1:0]      waddr, wdata, raddr, rdata;

	logic               accept, out_free;
	logic               find_done;
	logic [NW-1:0]      find_root;
	logic [COUNT_W-1:0] next_count;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign red_start = accept && (mode == MODE_UNION);

	ufc_index_reduce #(
		.NODE_COUNT(NODE_COUNT)
	) u_reduce (
		.clk   (clk),
		.arst_n(arst_n),
		.start (red_start),
		.a_in  (node_a),
		.b_in  (node_b),
		.done  (red_done),
		.a_out (red_a),
		.b_out (red_b)
	);

	ufc_ram #(
		.WIDTH(NW),
		.DEPTH(NODE_COUNT)
	) u_parent (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// memory port and find completion
	always_comb begin
		we        = 1'b0;
		waddr     = n_q;
		wdata     = root_q;
		raddr     = cur_q;
		find_done = 1'b0;
		find_root = root_q;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = clr_q;
			end
			ST_WALK: begin
				if (rdata == cur_q) begin
					find_root = cur_q;
					if (start_q == cur_q) begin
						find_done = 1'b1;
					end else begin
						raddr = start_q;
					end
				end else begin
					raddr = rdata;
				end
			end
			ST_COMP: begin
				we = 1'b1;
				if (rdata == root_q) begin
					find_done = 1'b1;
				end else begin
					raddr = rdata;
				end
			end
			ST_LINK: begin
				we    = 1'b1;
				waddr = ra_q;
				wdata = root_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		next_count = count_q;
		if (mode_q == MODE_ACTIVATE) begin
			if (count_q < COUNT_W'(LIMIT)) begin
				next_count = count_q + 1'b1;
			end
		end else if (merged_q && (count_q != '0)) begin
			next_count = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			phase_q     <= 1'b0;
			merged_q    <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NW'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						merged_q <= 1'b0;
						phase_q  <= 1'b0;
						state_q  <= (mode == MODE_UNION) ? ST_MOD : ST_DONE;
					end
				end
				ST_MOD: begin
					if (red_done) begin
						state_q <= ST_FSTART;
					end
				end
				ST_FSTART: begin
					state_q <= ST_WALK;
				end
				ST_WALK, ST_COMP: begin
					if (find_done) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							state_q <= ST_FSTART;
						end else if (ra_q != find_root) begin
							state_q <= ST_LINK;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (state_q == ST_WALK && rdata == cur_q) begin
						state_q <= ST_COMP;
					end
				end
				ST_LINK: begin
					merged_q <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						count_q     <= next_count;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
		end
		if (state_q == ST_MOD && red_done) begin
			cur_q   <= red_a;
			start_q <= red_a;
			b_q     <= red_b;
		end
		if (state_q inside {ST_WALK, ST_COMP}) begin
			if (find_done) begin
				root_q <= find_root;
				if (!phase_q) begin
					ra_q    <= find_root;
					cur_q   <= b_q;
					start_q <= b_q;
				end
			end else if (state_q == ST_WALK) begin
				if (rdata == cur_q) begin
					root_q <= cur_q;
					n_q    <= start_q;
				end else begin
					cur_q <= rdata;
				end
			end else begin
				n_q <= rdata;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_count_q  <= next_count;
			out_merged_q <= merged_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign component_count = out_count_q;
	assign merged          = out_merged_q;

`ifndef SYNTHESIS
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(LIMIT))
		else $error("component count above limit");

	a_comp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (n_q != root_q))
		else $error("compression writes the root itself");

	a_link_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK) |-> (ra_q != root_q))
		else $error("link of a root under itself");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside completion");

	a_merge_only_union: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && merged_q) |-> (mode_q == MODE_UNION))
		else $error("merge flagged on an activate item");
`endif

endmodule

FILE: design/ufc_ram.sv
// ----------------------------------------------------------------------------
// ufc_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read. Read of an address written in the same cycle gives the
// old data.
// ----------------------------------------------------------------------------
module ufc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ufc_index_reduce.sv
// ----------------------------------------------------------------------------
// ufc_index_reduce
// Reduces both node fields modulo the node count. When the node count
// covers the whole field the indexes are registered as they are; otherwise
// a registered reciprocal multiply and a registered multiply-back give the remainder.
// ----------------------------------------------------------------------------
module ufc_index_reduce #(
	parameter int NODE_COUNT = ufc_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ufc_pkg::FIELD_W-1:0]   a_in,
	input  logic [ufc_pkg::FIELD_W-1:0]   b_in,
	output logic                          done,
	output logic [$clog2(NODE_COUNT)-1:0] a_out,
	output logic [$clog2(NODE_COUNT)-1:0] b_out
);
	import ufc_pkg::*;

	localparam int NW       = $clog2(NODE_COUNT);
	localparam bit NEED_MOD = NODE_COUNT < (1 << FIELD_W);

	generate
		if (NEED_MOD) begin : g_recip
			localparam int SHIFT = FIELD_W + NW;
			localparam int PW    = 2 * FIELD_W + 2;
			localparam logic [PW-1:0] RECIP =
				PW'(((64'd1 << SHIFT) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT));
			localparam logic [FIELD_W-1:0] DIVISOR = FIELD_W'(NODE_COUNT);

			logic [FIELD_W-1:0] a_s1, b_s1, qa_s1, qb_s1;
			logic [PW-1:0]      prod_a, prod_b;
			logic [FIELD_W-1:0] rem_a, rem_b;
			logic [NW-1:0]      ra_q, rb_q;
			logic               busy_s1, done_q;

			// quotient by reciprocal multiply, exact for every field value
			assign prod_a = PW'(a_in) * RECIP;
			assign prod_b = PW'(b_in) * RECIP;
			assign rem_a  = a_s1 - qa_s1 * DIVISOR;
			assign rem_b  = b_s1 - qb_s1 * DIVISOR;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_s1 <= 1'b0;
					done_q  <= 1'b0;
				end else begin
					busy_s1 <= start;
					done_q  <= busy_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					a_s1  <= a_in;
					b_s1  <= b_in;
					qa_s1 <= FIELD_W'(prod_a >> SHIFT);
					qb_s1 <= FIELD_W'(prod_b >> SHIFT);
				end
				if (busy_s1) begin
					ra_q <= NW'(rem_a);
					rb_q <= NW'(rem_b);
				end
			end

			assign done  = done_q;
			assign a_out = ra_q;
			assign b_out = rb_q;
		end else begin : g_pass
			logic [NW-1:0] a_q, b_q;
			logic          done_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					a_q <= NW'(a_in);
					b_q <= NW'(b_in);
				end
			end

			assign done  = done_q;
			assign a_out = a_q;
			assign b_out = b_q;
		end
	endgenerate

endmodule

FILE: sim/tb_union_find_component_counter.sv
// ----------------------------------------------------------------------------
// tb_union_find_component_counter
// Self-checking bench for the union-find component counter. A table of
// directed items covers reset state, the count floor, self and repeated
// unions and field extremes. It is followed by random items: broad noise,
// tight node pools and deep chains that exercise path compression. Random
// stalls and gaps are applied on both channels, with one long output hold
// and full drains. The run ends with a burst of items with no idling.
// Checks use given table values, else an in-bench disjoint-set predictor.
// ----------------------------------------------------------------------------
module tb_union_find_component_counter;

	import ufc_pkg::*;

	localparam int NODES          = NODE_COUNT_DEF;
	localparam logic [COUNT_W-1:0] COUNT_TOP =
		COUNT_W'((NODES > COUNT_MAX) ? COUNT_MAX : NODES);
	localparam int RANDOM_ITEMS   = 900;
	localparam int TAIL_ITEMS     = 28;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic [COUNT_W-1:0] total;
		logic               joined;
	} tally_t;

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic               known;
		logic [COUNT_W-1:0] total;
		logic               joined;
	} probe_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic               mode      = MODE_ACTIVATE;
	logic [FIELD_W-1:0] node_a    = '0;
	logic [FIELD_W-1:0] node_b    = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COUNT_W-1:0] component_count;
	logic               merged;

	logic [FIELD_W-1:0] parent_of [NODES];
	logic [COUNT_W-1:0] comp_total = '0;
	tally_t             tally_due [$];
	tally_t             head_due;
	int                 errors        = 0;
	int                 hold_requests = 0;
	bit                 idle_on       = 1'b1;
	bit                 quiet         = 1'b0;

	probe_t probe_rows [22] = '{
		// count floor, already joined, self union
		'{MODE_UNION,    10'd0,    10'd1,    1'b1, 11'd0, 1'b1},
		'{MODE_UNION,    10'd1,    10'd0,    1'b1, 11'd0, 1'b0},
		'{MODE_UNION,    10'd1023, 10'd1023, 1'b1, 11'd0, 1'b0},
		// repeated activate counts again
		'{MODE_ACTIVATE, 10'd1023, 10'd0,    1'b1, 11'd1, 1'b0},
		'{MODE_ACTIVATE, 10'd1023, 10'd1023, 1'b1, 11'd2, 1'b0},
		'{MODE_ACTIVATE, 10'd0,    10'd1023, 1'b1, 11'd3, 1'b0},
		'{MODE_ACTIVATE, 10'd512,  10'd511,  1'b1, 11'd4, 1'b0},
		// build a chain, then walk it from the bottom
		'{MODE_UNION,    10'd2,    10'd3,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd3,    10'd4,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd4,    10'd5,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd5,    10'd6,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd6,    10'd7,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd2,    10'd1023, 1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd3,    10'd2,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd7,    10'd1023, 1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd0,    10'd1023, 1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd1023, 10'd512,  1'b0, 11'd0, 1'b0},
		'{MODE_ACTIVATE, 10'd0,    10'd0,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd1,    10'd5,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd1023, 10'd0,    1'b0, 11'd0, 1'b0},
		'{MODE_UNION,    10'd682,  10'd341,  1'b0, 11'd0, 1'b0},
		'{MODE_ACTIVATE, 10'd341,  10'd682,  1'b0, 11'd0, 1'b0}
	};

	union_find_component_counter DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.node_a          (node_a),
		.node_b          (node_b),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.component_count (component_count),
		.merged          (merged)
	);

	always #6 clk = ~clk;

	initial begin
		for (int i = 0; i < NODES; i++) parent_of[i] = FIELD_W'(i);
	end

	// root lookup with path compression on the walked path
	function automatic logic [FIELD_W-1:0] root_compress(input logic [FIELD_W-1:0] n);
		logic [FIELD_W-1:0] r;
		logic [FIELD_W-1:0] nxt;
		int                 steps;
		r = n;
		steps = 0;
		while (parent_of[r] != r && steps < NODES) begin
			r = parent_of[r];
			steps++;
		end
		steps = 0;
		while (n != r && steps < NODES) begin
			nxt = parent_of[n];
			parent_of[n] = r;
			n = nxt;
			steps++;
		end
		return r;
	endfunction

	function automatic tally_t predict_item(input logic op, input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		tally_t             res;
		logic [FIELD_W-1:0] ra;
		logic [FIELD_W-1:0] rb;
		res.joined = 1'b0;
		if (op == MODE_ACTIVATE) begin
			if (comp_total < COUNT_TOP) comp_total++;
		end else begin
			ra = root_compress(a);
			rb = root_compress(b);
			if (ra != rb) begin
				parent_of[ra] = rb;
				res.joined = 1'b1;
				if (comp_total > 0) comp_total--;
			end
		end
		res.total = comp_total;
		return res;
	endfunction

	task automatic push_item(input logic op, input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b, input bit known, input tally_t known_val);
		tally_t predicted;
		mode     <= op;
		node_a   <= a;
		node_b   <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = predict_item(op, a, b);
		tally_due = {tally_due, (known ? known_val : predicted)};
		if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (tally_due.size() != 0) @(posedge clk);
	endtask

	// result side: random stalls plus one long hold on request
	initial begin : result_side
		int n;
		int holds_done;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 16);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (tally_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got count %0d merged %0b",
					$time, component_count, merged);
			end else begin
				head_due = tally_due.pop_front();
				if (component_count !== head_due.total) begin
					errors++;
					$display("%0t: component_count expected %0d got %0d",
						$time, head_due.total, component_count);
				end
				if (merged !== head_due.joined) begin
					errors++;
					$display("%0t: merged expected %0b got %0b", $time, head_due.joined, merged);
				end
			end
		end
	end

	initial begin : watchdog
		int stuck_cycles;
		stuck_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) break;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		tally_t             known_val;
		logic               op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] pool_base;
		logic [FIELD_W-1:0] chain_head;
		logic [FIELD_W-1:0] chain_start;
		int                 kind;
		int                 r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i]) begin
			known_val.total  = probe_rows[i].total;
			known_val.joined = probe_rows[i].joined;
			push_item(probe_rows[i].op, probe_rows[i].a, probe_rows[i].b,
				probe_rows[i].known, known_val);
		end
		drain_results();

		kind = 0;
		pool_base = '0;
		chain_head = '0;
		chain_start = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				quiet       = ($urandom_range(0, 3) == 0);
				kind        = $urandom_range(0, 2);
				pool_base   = FIELD_W'($urandom_range(0, NODES - 32));
				chain_head  = FIELD_W'($urandom_range(0, NODES - 1));
				chain_start = chain_head;
			end
			if (n == 300) hold_requests++;
			if (n == 600) drain_results();
			r = $urandom_range(0, 9);
			case (kind)
				0: begin
					op = (r < 3) ? MODE_ACTIVATE : MODE_UNION;
					a  = FIELD_W'($urandom_range(0, NODES - 1));
					b  = FIELD_W'($urandom_range(0, NODES - 1));
				end
				1: begin
					op = (r < 2) ? MODE_ACTIVATE : MODE_UNION;
					a  = pool_base + FIELD_W'($urandom_range(0, 31));
					b  = (r == 9) ? a : pool_base + FIELD_W'($urandom_range(0, 31));
				end
				default: begin
					if (r < 7) begin
						op = MODE_UNION;
						a  = chain_head;
						b  = FIELD_W'($urandom_range(0, NODES - 1));
						chain_head = b;
					end else if (r < 9) begin
						op = MODE_UNION;
						a  = chain_start;
						b  = FIELD_W'($urandom_range(0, NODES - 1));
					end else begin
						op = MODE_ACTIVATE;
						a  = FIELD_W'($urandom_range(0, NODES - 1));
						b  = FIELD_W'($urandom_range(0, NODES - 1));
					end
				end
			endcase
			push_item(op, a, b, 1'b0, '0);
		end

		// last part: no idling
		idle_on = 1'b0;
		repeat (TAIL_ITEMS) begin
			op = ($urandom_range(0, 1) == 0) ? MODE_ACTIVATE : MODE_UNION;
			a  = FIELD_W'($urandom_range(0, NODES - 1));
			b  = FIELD_W'($urandom_range(0, NODES - 1));
			push_item(op, a, b, 1'b0, '0);
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/ufc_pkg.sv
design/ufc_ram.sv
design/ufc_index_reduce.sv
design/union_find_component_counter.sv
sim/tb_union_find_component_counter.sv
